// ===== design/hca_pkg.sv =====
// ----------------------------------------------------------------------------
// hca_pkg
// Shared widths, constants, stage record and arctangent table for the
// compass heading pipeline.
// ----------------------------------------------------------------------------
package hca_pkg;

   // sample and result widths
   localparam int AXIS_W    = 12;
   localparam int DECL_W    = 15;
   localparam int HEADING_W = 15;

   // internal datapath widths
   localparam int VEC_W     = 32;   // vector, sample scaled by 2^16
   localparam int FRAC_W    = 16;
   localparam int Z_W       = 24;   // angle in 1/16384 degree
   localparam int SUM_W     = 17;   // rounded angle plus declination
   localparam int TBL_IDX_W = 5;
   localparam int TBL_LEN   = 24;

   localparam logic signed [Z_W-1:0]    HALF_TURN_FINE = 24'sd2949120;
   localparam logic signed [Z_W-1:0]    ROUND_HALF     = 24'sd128;
   localparam int                       ROUND_SHIFT    = 8;
   localparam logic signed [SUM_W-1:0]  FULL_TURN      = 17'sd23040;
   localparam logic signed [DECL_W-1:0] DECL_RESET     = 15'sd284;

   // one item in flight through the rotation stages
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [Z_W-1:0]   z;
      logic                    zero;   // both axes were zero
   } hca_vec_type;

   // round(atan(2^-i) in degrees * 16384)
   function automatic logic signed [Z_W-1:0] hca_atan(input logic [TBL_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 24'sd737280;
         5'd1:    val = 24'sd435242;
         5'd2:    val = 24'sd229970;
         5'd3:    val = 24'sd116736;
         5'd4:    val = 24'sd58595;
         5'd5:    val = 24'sd29326;
         5'd6:    val = 24'sd14667;
         5'd7:    val = 24'sd7334;
         5'd8:    val = 24'sd3667;
         5'd9:    val = 24'sd1833;
         5'd10:   val = 24'sd917;
         5'd11:   val = 24'sd458;
         5'd12:   val = 24'sd229;
         5'd13:   val = 24'sd115;
         5'd14:   val = 24'sd57;
         5'd15:   val = 24'sd29;
         5'd16:   val = 24'sd14;
         5'd17:   val = 24'sd7;
         5'd18:   val = 24'sd4;
         5'd19:   val = 24'sd2;
         5'd20:   val = 24'sd1;
         default: val = 24'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/hca_req_if.sv =====
// ----------------------------------------------------------------------------
// hca_req_if
// Sample channel: valid/ready handshake with the X and Y field values.
// ----------------------------------------------------------------------------
interface hca_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [hca_pkg::AXIS_W-1:0] x_axis;
   logic signed [hca_pkg::AXIS_W-1:0] y_axis;

   modport source (output valid, output x_axis, output y_axis, input ready);
   modport sink   (input valid, input x_axis, input y_axis, output ready);
endinterface

// ===== design/hca_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hca_rsp_if
// Heading channel: valid/ready handshake with the wrapped heading.
// ----------------------------------------------------------------------------
interface hca_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hca_pkg::HEADING_W-1:0]  heading;

   modport source (output valid, output heading, input ready);
   modport sink   (input valid, input heading, output ready);
endinterface

// ===== design/hca_pre.sv =====
// ----------------------------------------------------------------------------
// hca_pre
// Entry stage: folds the left half-plane onto the right one, scales the
// sample to the vector format and flags the zero vector.
// ----------------------------------------------------------------------------
module hca_pre (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  logic signed [hca_pkg::AXIS_W-1:0] x_axis,
   input  logic signed [hca_pkg::AXIS_W-1:0] y_axis,
   output logic                              out_valid,
   output hca_pkg::hca_vec_type              out_vec
);
   import hca_pkg::*;

   localparam int NEG_W = AXIS_W + 1;

   logic                    valid_ff;
   hca_vec_type             vec_ff, vec_in;
   logic signed [NEG_W-1:0] xn, yn;

   // negate into the right half-plane, one extra bit for -2048
   always_comb begin
      if (x_axis[AXIS_W-1]) begin
         xn = -NEG_W'(x_axis);
         yn = -NEG_W'(y_axis);
      end else begin
         xn = NEG_W'(x_axis);
         yn = NEG_W'(y_axis);
      end
      vec_in.x    = {{(VEC_W-NEG_W-FRAC_W){xn[NEG_W-1]}}, xn, {FRAC_W{1'b0}}};
      vec_in.y    = {{(VEC_W-NEG_W-FRAC_W){yn[NEG_W-1]}}, yn, {FRAC_W{1'b0}}};
      vec_in.z    = x_axis[AXIS_W-1] ? HALF_TURN_FINE : '0;
      vec_in.zero = (x_axis == '0) && (y_axis == '0);
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
endmodule

// ===== design/hca_rot.sv =====
// ----------------------------------------------------------------------------
// hca_rot
// One vectoring micro-rotation: drives y toward zero by a shifted add and
// accumulates the matching arctangent step.
// ----------------------------------------------------------------------------
module hca_rot #(
   parameter int STAGE_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  hca_pkg::hca_vec_type in_vec,
   output logic                 out_valid,
   output hca_pkg::hca_vec_type out_vec
);
   import hca_pkg::*;

   logic                    valid_ff;
   hca_vec_type             vec_ff, vec_in;
   logic signed [VEC_W-1:0] xs, ys;
   logic signed [Z_W-1:0]   step;

   assign xs   = in_vec.x >>> STAGE_IDX;
   assign ys   = in_vec.y >>> STAGE_IDX;
   assign step = hca_atan(TBL_IDX_W'(STAGE_IDX));

   // rotate clockwise while y is non-negative
   always_comb begin
      vec_in.zero = in_vec.zero;
      if (!in_vec.y[VEC_W-1]) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + step;
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - step;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
endmodule

// ===== design/hca_post.sv =====
// ----------------------------------------------------------------------------
// hca_post
// Exit stage: rounds the angle to 1/64 degree, adds the declination and
// wraps once into the full turn. Holds the output register.
// ----------------------------------------------------------------------------
module hca_post (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  hca_pkg::hca_vec_type              in_vec,
   input  logic signed [hca_pkg::DECL_W-1:0] declination,
   output logic                              out_valid,
   output logic [hca_pkg::HEADING_W-1:0]     heading
);
   import hca_pkg::*;

   logic                    valid_ff;
   logic [HEADING_W-1:0]    heading_ff, heading_in;
   logic signed [Z_W-1:0]   rounded;
   logic signed [SUM_W-1:0] raw, sum, wrapped;

   // round half up, zero vector reads as angle zero
   always_comb begin
      rounded = (in_vec.z + ROUND_HALF) >>> ROUND_SHIFT;
      raw     = in_vec.zero ? '0 : SUM_W'(rounded);
      sum     = raw + SUM_W'(declination);
      priority if (sum < 0) begin
         wrapped = sum + FULL_TURN;
      end else if (sum >= FULL_TURN) begin
         wrapped = sum - FULL_TURN;
      end else begin
         wrapped = sum;
      end
      heading_in = HEADING_W'(wrapped);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         heading_ff <= heading_in;
      end
   end

   assign out_valid = valid_ff;
   assign heading   = heading_ff;
endmodule

// ===== design/compass_heading_from_axes.sv =====
// ----------------------------------------------------------------------------
// compass_heading_from_axes
// Magnetometer heading: atan2(y, x) by a pipelined vectoring CORDIC, plus a
// programmable declination, wrapped to 0 .. just below 360 degrees.
//
//   channel   direction  payload                     handshake
//   req_ch    in         x_axis[11:0], y_axis[11:0]  valid/ready
//   rsp_ch    out        heading[14:0] (1/64 deg)    valid/ready
//   csr_*     in         declination[14:0] signed    write enable only
//
// A sample passes the entry stage, one register per micro-rotation, and the
// output register. One sample is taken per cycle while the pipe is not held.
// All stages advance together; while a result waits at the output with
// ready low, the whole pipe holds and req_ch.ready is low.
// Reset is synchronous and clears the stage valid bits; declination
// returns to 284 (4 deg 26 min).
// ----------------------------------------------------------------------------
module compass_heading_from_axes #(
   parameter int ANGLE_STAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   hca_req_if.sink                           req_ch,
   hca_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic signed [hca_pkg::DECL_W-1:0] csr_wdata
);
   import hca_pkg::*;

   logic                    pipe_en;
   logic signed [DECL_W-1:0] csr_declination_ff;
   logic [ANGLE_STAGES:0]   stage_valid;
   hca_vec_type             stage_vec [0:ANGLE_STAGES];

   // whole pipe moves unless the output holds an untaken result
   assign pipe_en      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   // declination register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_declination_ff <= DECL_RESET;
      end else if (csr_we) begin
         csr_declination_ff <= csr_wdata;
      end
   end

   // entry stage
   hca_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (req_ch.valid),
      .x_axis    (req_ch.x_axis),
      .y_axis    (req_ch.y_axis),
      .out_valid (stage_valid[0]),
      .out_vec   (stage_vec[0])
   );

   // micro-rotation stages
   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_rot
      hca_rot #(
         .STAGE_IDX (i)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_en),
         .in_valid  (stage_valid[i]),
         .in_vec    (stage_vec[i]),
         .out_valid (stage_valid[i+1]),
         .out_vec   (stage_vec[i+1])
      );
   end

   // rounding, declination and wrap
   hca_post u_post (
      .clock       (clock),
      .reset       (reset),
      .enable      (pipe_en),
      .in_valid    (stage_valid[ANGLE_STAGES]),
      .in_vec      (stage_vec[ANGLE_STAGES]),
      .declination (csr_declination_ff),
      .out_valid   (rsp_ch.valid),
      .heading     (rsp_ch.heading)
   );

   // heading always within one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.heading < HEADING_W'(FULL_TURN)))
      else $error("heading outside one turn");

   // a stalled pipe keeps every stage valid bit
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(stage_valid))
      else $error("pipeline moved during stall");

   // a new result comes only from the last rotation stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(stage_valid[ANGLE_STAGES]))
      else $error("result without an item in the last stage");

endmodule
